[hw/rtl/p2ct_pkg.sv]
// ----------------------------------------------------------------------------
// p2ct_pkg: shared types and constants for the polar-to-cartesian tracker
// Field widths, Q.30 angle constants, the CORDIC arctangent table, the job
// record passed from the front end to the rotation engine, and FSM states.
// ----------------------------------------------------------------------------
package p2ct_pkg;

    // Port field widths
    localparam int ANGLE_W  = 20;
    localparam int DIST_W   = 17;
    localparam int FOV_W    = 19;
    localparam int OUT_W    = 17;
    localparam int RANGE_W  = 16;

    // Defaults for top-level parameters
    localparam int CORDIC_STEPS_DEF = 16;

    // Angle format of the input fields
    localparam int ANGLE_FRAC_BITS = 16;

    // Relative angle fov - 2*bearing, its magnitude moved to Q.30
    localparam int D2_W   = ANGLE_W + 2;
    localparam int MAG_SH = 29 - ANGLE_FRAC_BITS;
    localparam int MAG_W  = D2_W - 1 + MAG_SH;
    localparam int RED_W  = 33;              // magnitude modulo two pi
    localparam int FOLD_W = 35;              // signed work width for folding
    localparam int Q_W    = 32;              // folded angle, signed Q.30
    localparam int CORDIC_W = 34;            // rotation datapath width
    localparam int ATAN_W   = 30;
    localparam int ATAN_IDX_W = 5;

    localparam logic [MAG_W-1:0] Q30_TWO_PI_M = MAG_W'(64'd6746518852);
    localparam logic signed [FOLD_W-1:0] Q30_PI      = 35'sd3373259426;
    localparam logic signed [FOLD_W-1:0] Q30_HALF_PI = 35'sd1686629713;
    localparam logic signed [FOLD_W-1:0] Q30_TWO_PI  = 35'sd6746518852;
    localparam logic signed [FOLD_W-1:0] Q30_FOLD_LIM = Q30_TWO_PI - Q30_HALF_PI;
    localparam logic signed [CORDIC_W-1:0] Q30_GAIN  = 34'sd652032874;
    localparam int Q30_SH = 30;

    // Item handed from front end to rotation engine
    typedef struct packed {
        logic signed [Q_W-1:0] angle;   // folded into [-pi/2, pi/2]
        logic                  cneg;    // negate cosine after rotation
        logic                  x_neg;   // half field of view not above bearing
        logic [RANGE_W-1:0]    range;
    } t_job;

    // Rotation engine states
    typedef enum logic [1:0] {
        B_IDLE,
        B_ROT,
        B_MUL,
        B_RND
    } t_bstate;

    // Truncated arctangent of 2^-idx in Q.30
    function automatic logic [ATAN_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v[ATAN_W-1:0];
    endfunction

endpackage

[hw/rtl/p2ct_front.sv]
// ----------------------------------------------------------------------------
// p2ct_front: item intake and angle reduction
// Updates the saturating bearing and range, forms the relative angle, takes
// it modulo two pi and folds it into [-pi/2, pi/2] for the rotation engine.
// ----------------------------------------------------------------------------
module p2ct_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_func,
    input  logic signed [p2ct_pkg::ANGLE_W-1:0] i_angle_value,
    input  logic signed [p2ct_pkg::DIST_W-1:0]  i_distance_value,
    input  logic [p2ct_pkg::FOV_W-1:0]          i_field_of_view,
    output logic                                o_push,
    output p2ct_pkg::t_job                      o_job,
    input  logic                                i_full
);
    import p2ct_pkg::*;

    localparam logic signed [ANGLE_W-1:0] BEAR_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
    localparam logic signed [ANGLE_W-1:0] BEAR_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

    logic signed [ANGLE_W-1:0] r_bearing, n_bearing;
    logic [RANGE_W-1:0]        r_range, n_range;
    logic [FOV_W-1:0]          r_fov;
    logic                      r_s1_valid;
    logic                      r_s2_valid;
    logic [RED_W-1:0]          r_a0;
    logic                      r_s2_xneg;
    logic [RANGE_W-1:0]        r_s2_range;

    logic accept, s1_adv, s2_adv;
    logic signed [ANGLE_W:0]   bsum;
    logic signed [RANGE_W+1:0] rsum;
    logic signed [D2_W-1:0]    d2;
    logic [D2_W-1:0]           absd;
    logic [MAG_W-1:0]          mag;
    logic [RED_W-1:0]          a0;
    logic signed [FOLD_W-1:0]  a0e, afold;
    logic                      cneg;

    // Stage handshakes: stage 1 reads the live state, so hold intake while it stalls
    assign s2_adv  = r_s2_valid && !i_full;
    assign s1_adv  = r_s1_valid && (!r_s2_valid || s2_adv);
    assign o_ready = !r_s1_valid || s1_adv;
    assign accept  = i_valid && o_ready;
    assign o_push  = s2_adv;

    // Bearing and range update: load when i_func is low, saturating add when high
    always_comb begin
        bsum = {i_angle_value[ANGLE_W-1], i_angle_value} + {r_bearing[ANGLE_W-1], r_bearing};
        rsum = $signed({2'b00, r_range}) +
               $signed({i_distance_value[DIST_W-1], i_distance_value});
        if (!i_func) begin
            n_bearing = i_angle_value;
            n_range   = i_distance_value[DIST_W-1] ? '0 : i_distance_value[RANGE_W-1:0];
        end else begin
            if (bsum[ANGLE_W] != bsum[ANGLE_W-1]) begin
                n_bearing = bsum[ANGLE_W] ? BEAR_MIN : BEAR_MAX;
            end else begin
                n_bearing = bsum[ANGLE_W-1:0];
            end
            if (rsum[RANGE_W+1]) begin
                n_range = '0;
            end else if (rsum[RANGE_W]) begin
                n_range = '1;
            end else begin
                n_range = rsum[RANGE_W-1:0];
            end
        end
    end

    // Relative angle magnitude in Q.30, reduced modulo two pi
    always_comb begin
        d2   = $signed({3'b000, r_fov}) - $signed({r_bearing[ANGLE_W-1], r_bearing, 1'b0});
        absd = d2[D2_W-1] ? D2_W'(-d2) : D2_W'(d2);
        mag  = {absd[D2_W-2:0], {MAG_SH{1'b0}}};
        a0   = (mag >= Q30_TWO_PI_M) ? RED_W'(mag - Q30_TWO_PI_M) : RED_W'(mag);
    end

    // Fold into [-pi/2, pi/2]; angles between pi/2 and 3*pi/2 flip the cosine
    always_comb begin
        a0e  = $signed({{(FOLD_W-RED_W){1'b0}}, r_a0});
        cneg = 1'b0;
        if (a0e <= Q30_HALF_PI) begin
            afold = a0e;
        end else if (a0e < Q30_FOLD_LIM) begin
            afold = Q30_PI - a0e;
            cneg  = 1'b1;
        end else begin
            afold = a0e - Q30_TWO_PI;
        end
        o_job.angle = afold[Q_W-1:0];
        o_job.cneg  = cneg;
        o_job.x_neg = r_s2_xneg;
        o_job.range = r_s2_range;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bearing  <= '0;
            r_range    <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_bearing <= n_bearing;
                r_range   <= n_range;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fov <= i_field_of_view;
        end
        if (s1_adv) begin
            r_a0       <= a0;
            r_s2_xneg  <= d2[D2_W-1] || (d2 == '0);
            r_s2_range <= r_range;
        end
    end

endmodule

[hw/rtl/p2ct_queue.sv]
// ----------------------------------------------------------------------------
// p2ct_queue: two-entry job queue
// Decouples the front end from the rotation engine so either can stall.
// ----------------------------------------------------------------------------
module p2ct_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  p2ct_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output p2ct_pkg::t_job o_job
);
    import p2ct_pkg::*;

    t_job       r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_entry[r_rd_ptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

endmodule

[hw/rtl/p2ct_back.sv]
// ----------------------------------------------------------------------------
// p2ct_back: CORDIC rotation engine and result scaling
// Rotates the gain vector by the folded angle one micro-step per cycle,
// scales sine and cosine by the range, rounds and holds the result item.
// ----------------------------------------------------------------------------
module p2ct_back #(
    parameter int CORDIC_STEPS = p2ct_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    input  p2ct_pkg::t_job                    i_job,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [p2ct_pkg::OUT_W-1:0] o_x_coord,
    output logic signed [p2ct_pkg::OUT_W-1:0] o_y_coord
);
    import p2ct_pkg::*;

    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam int PW     = RANGE_W + 1 + CORDIC_W;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
    localparam logic [PW-1:0] RND_HALF = PW'(1) << (Q30_SH - 1);

    t_bstate r_state, n_state;

    logic signed [CORDIC_W-1:0] r_x, r_y, r_z;
    logic [STEP_W-1:0]          r_step;
    logic                       r_cneg, r_xneg;
    logic [RANGE_W-1:0]         r_range;
    logic signed [PW-1:0]       r_px, r_py;
    logic                       r_out_valid;
    logic signed [OUT_W-1:0]    r_xo, r_yo;

    logic                       load_out;
    logic signed [CORDIC_W-1:0] xs, ys, at, xf;
    logic signed [RANGE_W:0]    rs;

    // Round half away from zero to an integer, clamp, apply the sign
    function automatic logic signed [OUT_W-1:0] scale_out(
        input logic signed [PW-1:0] p,
        input logic                 flip
    );
        logic              neg;
        logic [PW-1:0]     m;
        logic [PW-1:0]     s;
        logic [RANGE_W-1:0] q;
        neg = p[PW-1];
        m   = neg ? PW'(-p) : PW'(p);
        s   = m + RND_HALF;
        q   = (|s[PW-1:Q30_SH+RANGE_W]) ? '1 : s[Q30_SH+RANGE_W-1:Q30_SH];
        return (neg ^ flip) ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and controls
    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = B_ROT;
                end
            end
            B_ROT: begin
                if (r_step == STEP_LAST) begin
                    n_state = B_MUL;
                end
            end
            B_MUL: begin
                n_state = B_RND;
            end
            B_RND: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // One micro-rotation
    assign xs = r_x >>> r_step;
    assign ys = r_y >>> r_step;
    assign at = CORDIC_W'(atan_q30(ATAN_IDX_W'(r_step)));
    assign xf = r_cneg ? -r_x : r_x;
    assign rs = $signed({1'b0, r_range});

    // Rotation and scaling datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (o_pop) begin
                    r_x     <= Q30_GAIN;
                    r_y     <= '0;
                    r_z     <= CORDIC_W'(i_job.angle);
                    r_step  <= '0;
                    r_cneg  <= i_job.cneg;
                    r_xneg  <= i_job.x_neg;
                    r_range <= i_job.range;
                end
            end
            B_ROT: begin
                if (!r_z[CORDIC_W-1]) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end
                r_step <= r_step + STEP_W'(1);
            end
            B_MUL: begin
                r_px <= rs * xf;
                r_py <= rs * r_y;
            end
            default: begin
            end
        endcase
    end

    // Output register: hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_xo <= scale_out(r_py, r_xneg);
            r_yo <= scale_out(r_px, 1'b0);
        end
    end

    assign o_valid   = r_out_valid;
    assign o_x_coord = r_xo;
    assign o_y_coord = r_yo;

endmodule

[hw/rtl/polar_to_cartesian_tracker.sv]
// ----------------------------------------------------------------------------
// polar_to_cartesian_tracker: point tracker with CORDIC polar conversion
// Keeps a saturating bearing and range, and for every item emits the point
// in cartesian form relative to half the field of view.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   input   | in        | i_valid / o_ready  | i_func, i_angle_value,
//           |           |                    | i_distance_value, i_field_of_view
//   result  | out       | o_valid / i_ready  | o_x_coord, o_y_coord
//
// Each item yields one result. The rotation engine pops an item, runs
// CORDIC_STEPS micro-rotations, multiplies and rounds, and pops the next item
// only after the round. An accepted item passes the front-end stage registers,
// the queue, the engine states and the result register before it is valid.
// Reset is synchronous and clears bearing, range and all valid flags.
// A two-entry queue lets intake continue while the engine or the result
// register waits; the result register holds until i_ready.
// ----------------------------------------------------------------------------
module polar_to_cartesian_tracker #(
    parameter int CORDIC_STEPS = p2ct_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_func,
    input  logic signed [p2ct_pkg::ANGLE_W-1:0] i_angle_value,
    input  logic signed [p2ct_pkg::DIST_W-1:0]  i_distance_value,
    input  logic [p2ct_pkg::FOV_W-1:0]          i_field_of_view,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [p2ct_pkg::OUT_W-1:0]   o_x_coord,
    output logic signed [p2ct_pkg::OUT_W-1:0]   o_y_coord
);
    import p2ct_pkg::*;

    logic push, full, pop, empty;
    t_job job_in, job_out;

    // Intake, state update and angle reduction
    p2ct_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_func           (i_func),
        .i_angle_value    (i_angle_value),
        .i_distance_value (i_distance_value),
        .i_field_of_view  (i_field_of_view),
        .o_push           (push),
        .o_job            (job_in),
        .i_full           (full)
    );

    // Job queue between front end and engine
    p2ct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (job_out)
    );

    // Rotation, scaling and result register
    p2ct_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .i_job     (job_out),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_x_coord (o_x_coord),
        .o_y_coord (o_y_coord)
    );

endmodule
